// ===== sv/pps_pkg.sv =====
// Shared types and codes for the preemptive priority scheduler.
package pps_pkg;

    // Action codes of an input item
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam logic [15:0] CLOCK_MAX = 16'hFFFF;

    // Input item: load a job or advance one tick
    typedef struct packed {
        logic        action;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  prio;
    } req_item_t;

    // Result item of one tick
    typedef struct packed {
        logic [4:0]  job_id;
        logic        idle;
        logic        finished;
        logic [15:0] completion_time;
        logic [15:0] turnaround;
        logic [15:0] waiting;
        logic        all_done;
    } rsp_item_t;

    // One job slot as held in the job table
    typedef struct packed {
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [15:0] left;
        logic [7:0]  prio;
    } job_rec_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic start;
        logic step;
        logic commit;
    } pps_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic scan_end;
    } pps_status_t;

endpackage

// ===== sv/pps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/pps_datapath.sv =====
// Datapath: job table, counters, clock, slot scan and result register.
module pps_datapath #(
    parameter int MAX_JOBS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pps_pkg::req_item_t   req,
    input  pps_pkg::pps_cmd_t    cmd,
    output pps_pkg::pps_status_t status,
    output pps_pkg::rsp_item_t   rsp
);

    localparam int AW  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CW  = $clog2(MAX_JOBS + 1);
    localparam int IDW = (AW + 1 > 5) ? AW + 1 : 5;

    logic [CW-1:0] loaded_reg, loaded_next;
    logic [CW-1:0] finished_reg, finished_next;
    logic [15:0]   clock_reg, clock_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          rd_pend_reg, rd_pend_next;
    logic [AW-1:0] rd_slot_reg, rd_slot_next;
    logic          found_reg, found_next;
    logic [AW-1:0] best_slot_reg, best_slot_next;
    pps_pkg::job_rec_t best_rec_reg, best_rec_next;
    pps_pkg::rsp_item_t rsp_reg, rsp_next;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    pps_pkg::job_rec_t mem_wdata;
    logic [AW-1:0]     mem_raddr;
    pps_pkg::job_rec_t mem_rdata;

    logic              load_ok;
    logic              issue;
    logic              cand;
    logic [15:0]       clk_inc;
    logic [15:0]       left_dec;
    logic              fin;
    logic [15:0]       tat;
    logic [15:0]       wt;
    logic [IDW-1:0]    id_wide;
    logic [CW-1:0]     fin_count;

    pps_ram #(
        .WIDTH($bits(pps_pkg::job_rec_t)),
        .DEPTH(MAX_JOBS)
    ) u_jobs (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    // Scan read issue and candidate test on the returned slot
    assign load_ok   = cmd.load && (loaded_reg < CW'(MAX_JOBS));
    assign issue     = cmd.step && (idx_reg < loaded_reg);
    assign mem_raddr = idx_reg[AW-1:0];
    assign cand      = rd_pend_reg && (mem_rdata.arrival <= clock_reg) &&
                       (mem_rdata.left != 16'd0) &&
                       (!found_reg || (mem_rdata.prio < best_rec_reg.prio));
    assign status.scan_end = (idx_reg == loaded_reg) && !rd_pend_reg;

    // Commit arithmetic for the chosen job
    assign clk_inc   = (clock_reg == pps_pkg::CLOCK_MAX) ? clock_reg : clock_reg + 16'd1;
    assign left_dec  = best_rec_reg.left - 16'd1;
    assign fin       = found_reg && (left_dec == 16'd0);
    assign tat       = clk_inc - best_rec_reg.arrival;
    assign wt        = (tat >= best_rec_reg.burst) ? tat - best_rec_reg.burst : 16'd0;
    assign id_wide   = IDW'(best_slot_reg) + IDW'(1);
    assign fin_count = finished_reg + (fin ? CW'(1) : CW'(0));

    // Table write: new job on load, decremented service on commit
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = loaded_reg[AW-1:0];
        mem_wdata = '{arrival: req.arrival, burst: req.burst,
                      left: req.burst, prio: req.prio};
        if (load_ok)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.commit && found_reg)
        begin
            mem_we         = 1'b1;
            mem_waddr      = best_slot_reg;
            mem_wdata      = best_rec_reg;
            mem_wdata.left = left_dec;
        end
    end

    // Next state of counters, scan and result
    always_comb
    begin
        loaded_next    = loaded_reg;
        finished_next  = finished_reg;
        clock_next     = clock_reg;
        idx_next       = idx_reg;
        rd_pend_next   = issue;
        rd_slot_next   = idx_reg[AW-1:0];
        found_next     = found_reg;
        best_slot_next = best_slot_reg;
        best_rec_next  = best_rec_reg;
        rsp_next       = rsp_reg;

        if (load_ok)
        begin
            loaded_next = loaded_reg + CW'(1);
            if (req.burst == 16'd0)
            begin
                finished_next = finished_reg + CW'(1);
            end
        end

        if (cmd.start)
        begin
            idx_next     = '0;
            rd_pend_next = 1'b0;
            found_next   = 1'b0;
        end
        else
        begin
            if (issue)
            begin
                idx_next = idx_reg + CW'(1);
            end
            if (cand)
            begin
                found_next     = 1'b1;
                best_slot_next = rd_slot_reg;
                best_rec_next  = mem_rdata;
            end
        end

        if (cmd.commit)
        begin
            clock_next    = clk_inc;
            finished_next = fin_count;
            rsp_next      = '0;
            rsp_next.idle = !found_reg;
            if (found_reg)
            begin
                rsp_next.job_id = id_wide[4:0];
            end
            if (fin)
            begin
                rsp_next.finished        = 1'b1;
                rsp_next.completion_time = clk_inc;
                rsp_next.turnaround      = tat;
                rsp_next.waiting         = wt;
            end
            rsp_next.all_done = (fin_count == loaded_reg);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg   <= '0;
            finished_reg <= '0;
            clock_reg    <= '0;
            idx_reg      <= '0;
            rd_pend_reg  <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            loaded_reg   <= loaded_next;
            finished_reg <= finished_next;
            clock_reg    <= clock_next;
            idx_reg      <= idx_next;
            rd_pend_reg  <= rd_pend_next;
            found_reg    <= found_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_slot_reg   <= rd_slot_next;
        best_slot_reg <= best_slot_next;
        best_rec_reg  <= best_rec_next;
        rsp_reg       <= rsp_next;
    end

    assign rsp = rsp_reg;

endmodule

// ===== sv/pps_ctrl.sv =====
// Controller: sequences load, slot scan and commit, owns the handshakes.
module pps_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic                 req_action,
    input  logic                 rsp_stall,
    input  pps_pkg::pps_status_t status,
    output pps_pkg::pps_cmd_t    cmd,
    output logic                 req_stall,
    output logic                 rsp_valid
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       rsp_valid_reg, rsp_valid_next;
    logic       out_busy;

    assign out_busy  = rsp_valid_reg && rsp_stall;
    assign req_stall = (state_reg != S_IDLE);

    // Decide commands and next state
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        rsp_valid_next = out_busy;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_action == pps_pkg::ACT_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.step = 1'b1;
                if (status.scan_end)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                // hold until the result register is free
                if (!out_busy)
                begin
                    cmd.commit     = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

// ===== sv/preemptive_priority_scheduler.sv =====
// Top level of the preemptive priority scheduler.
// A load item writes the job into the next free slot of the job table
// (dropped once MAX_JOBS jobs are loaded). A tick item is accepted, the
// table RAM is read one slot per cycle through its registered read port,
// the scan ends and the result is committed. The result sits in an output
// register, so the next item is accepted while it waits; a tick stalls at
// commit only while the previous result is still stalled.
module preemptive_priority_scheduler #(
    parameter int MAX_JOBS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  pps_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output pps_pkg::rsp_item_t rsp
);

    pps_pkg::pps_cmd_t    cmd;
    pps_pkg::pps_status_t status;

    pps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_action(req.action),
        .rsp_stall (rsp_stall),
        .status    (status),
        .cmd       (cmd),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid)
    );

    pps_datapath #(
        .MAX_JOBS(MAX_JOBS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .status(status),
        .rsp   (rsp)
    );

endmodule

// ===== sv/pps_checker.sv =====
// Port-level checks for the preemptive priority scheduler, bound to the top.
module pps_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input pps_pkg::req_item_t req,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input pps_pkg::rsp_item_t rsp
);

    // A stalled result item holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result item changed");

    // A tick starts a scan, so the next cycle cannot take an item
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (req.action == pps_pkg::ACT_TICK) |=> req_stall)
        else $error("item accepted during slot scan");

    // An idle tick names no job and finishes none
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.idle |-> (rsp.job_id == 5'd0) && !rsp.finished)
        else $error("idle tick reports a job");

    // Timing fields are zero unless a job finished
    a_no_fin: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.finished |->
            (rsp.completion_time == 16'd0) && (rsp.turnaround == 16'd0) &&
            (rsp.waiting == 16'd0))
        else $error("timing fields set without completion");

    // Waiting never exceeds turnaround, turnaround never exceeds completion
    a_fin_order: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.finished |->
            (rsp.waiting <= rsp.turnaround) && (rsp.turnaround <= rsp.completion_time))
        else $error("inconsistent completion times");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
);

// ===== tb/sv/tb_preemptive_priority_scheduler.sv =====
// Self-checking testbench for the preemptive priority scheduler.
module tb_preemptive_priority_scheduler;

    localparam int MAX_SLOTS = 16;
    localparam int QUEUE_AHEAD = 4;
    localparam int HOLD_AFTER_TICKS = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 40;
    localparam int REPORT_LIMIT = 30;

    // Idle pattern of the two sides
    typedef enum logic [1:0] {
        PACE_RX_SLOW,
        PACE_TX_SLOW,
        PACE_FULL
    } pace_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    pps_pkg::req_item_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    pps_pkg::rsp_item_t rsp;

    pace_t pace = PACE_RX_SLOW;
    pps_pkg::req_item_t pending_items[$];
    pps_pkg::rsp_item_t tick_results_due[$];

    // Scheduler state as the checker sees it
    bit [15:0] sched_arrival[MAX_SLOTS];
    bit [15:0] sched_burst[MAX_SLOTS];
    bit [15:0] sched_left[MAX_SLOTS];
    bit [7:0]  sched_prio[MAX_SLOTS];
    int        sched_count = 0;
    int        sched_done = 0;
    bit [15:0] sched_clock = 16'd0;

    // Stimulus bookkeeping
    int gen_clock = 0;

    int hold_left = 0;
    bit long_hold_done = 1'b0;
    int mismatches = 0;
    int ticks_checked = 0;
    int loads_taken = 0;
    int loads_dropped = 0;
    int completions = 0;
    int idle_ticks = 0;

    preemptive_priority_scheduler #(
        .MAX_JOBS(MAX_SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always #1 clk = ~clk;

    // Apply one accepted item to the scheduler state; queue the tick result
    task automatic run_scheduler(input pps_pkg::req_item_t it);
        int i;
        int pick;
        bit found;
        bit [7:0] best;
        bit [15:0] tat;
        pps_pkg::rsp_item_t r;
        if (it.action == pps_pkg::ACT_LOAD)
        begin
            if (sched_count < MAX_SLOTS)
            begin
                sched_arrival[sched_count] = it.arrival;
                sched_burst[sched_count] = it.burst;
                sched_left[sched_count] = it.burst;
                sched_prio[sched_count] = it.prio;
                if (it.burst == 16'd0)
                    sched_done++;
                sched_count++;
                loads_taken++;
            end
            else
                loads_dropped++;
        end
        else
        begin
            found = 1'b0;
            pick = 0;
            best = 8'd0;
            // Pick the arrived job with service left and the smallest priority
            for (i = 0; i < sched_count; i++)
            begin
                if (sched_arrival[i] <= sched_clock && sched_left[i] != 16'd0 &&
                    (!found || sched_prio[i] < best))
                begin
                    found = 1'b1;
                    best = sched_prio[i];
                    pick = i;
                end
            end
            if (sched_clock != pps_pkg::CLOCK_MAX)
                sched_clock++;
            r = '0;
            if (!found)
                r.idle = 1'b1;
            else
            begin
                r.job_id = 5'(pick + 1);
                sched_left[pick]--;
                if (sched_left[pick] == 16'd0)
                begin
                    tat = sched_clock - sched_arrival[pick];
                    sched_done++;
                    r.finished = 1'b1;
                    r.completion_time = sched_clock;
                    r.turnaround = tat;
                    r.waiting = (tat >= sched_burst[pick]) ? tat - sched_burst[pick] : 16'd0;
                end
            end
            r.all_done = (sched_done == sched_count);
            tick_results_due.insert(tick_results_due.size(), r);
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch at result %0d: %s is %0d, expected %0d",
                     ticks_checked, what, got, want);
    endtask

    // Queue an item, keeping only a few ahead of the driver
    task automatic offer(input pps_pkg::req_item_t it);
        while (pending_items.size() >= QUEUE_AHEAD)
            @(negedge clk);
        pending_items.insert(pending_items.size(), it);
        if (it.action == pps_pkg::ACT_TICK && gen_clock < 65535)
            gen_clock++;
    endtask

    task automatic offer_load(input logic [15:0] arr, input logic [15:0] bur,
                              input logic [7:0] pri);
        pps_pkg::req_item_t it;
        it.action = pps_pkg::ACT_LOAD;
        it.arrival = arr;
        it.burst = bur;
        it.prio = pri;
        offer(it);
    endtask

    // Tick items carry random content in the fields they ignore
    task automatic offer_ticks(input int n);
        pps_pkg::req_item_t it;
        int i;
        for (i = 0; i < n; i++)
        begin
            it.action = pps_pkg::ACT_TICK;
            it.arrival = 16'($urandom);
            it.burst = 16'($urandom);
            it.prio = 8'($urandom);
            offer(it);
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || req_valid || tick_results_due.size() != 0);
    endtask

    // Random load with an arrival near the planned clock
    task automatic offer_near_load(output logic [15:0] arr, output logic [7:0] pri);
        int sel;
        logic [15:0] bur;
        sel = $urandom_range(9);
        arr = 16'((gen_clock + $urandom_range(200) > 65535) ?
                  65535 : gen_clock + $urandom_range(200));
        pri = 8'($urandom);
        if (sel == 0)
            bur = 16'd0;
        else if (sel == 1)
            bur = 16'($urandom_range(3000, 1000));
        else
            bur = 16'($urandom_range(300, 1));
        offer_load(arr, bur, pri);
    endtask

    // Driver: predict accepted items, offer the next one with random gaps
    always @(posedge clk or negedge rst_n)
    begin : drive
        int gap_pct;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
                run_scheduler(req);
            // Hold a stalled item; otherwise advance
            if (!req_valid || !req_stall)
            begin
                case (pace)
                    PACE_RX_SLOW: gap_pct = 37;
                    PACE_TX_SLOW: gap_pct = 82;
                    default:      gap_pct = 0;
                endcase
                if (hold_left != 0)
                    gap_pct = 0;
                if (pending_items.size() != 0 && $urandom_range(99) >= gap_pct)
                begin
                    req_valid <= 1'b1;
                    req <= pending_items.pop_front();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted result, stall at random and once for long
    always @(posedge clk or negedge rst_n)
    begin : watch
        int next_hold;
        int stall_pct;
        pps_pkg::rsp_item_t want;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                ticks_checked++;
                if (tick_results_due.size() == 0)
                    report_mismatch("unexpected result, job_id", rsp.job_id, 0);
                else
                begin
                    want = tick_results_due.pop_front();
                    if (rsp.job_id !== want.job_id)
                        report_mismatch("job_id", rsp.job_id, want.job_id);
                    if (rsp.idle !== want.idle)
                        report_mismatch("idle", rsp.idle, want.idle);
                    if (rsp.finished !== want.finished)
                        report_mismatch("finished", rsp.finished, want.finished);
                    if (rsp.completion_time !== want.completion_time)
                        report_mismatch("completion_time", rsp.completion_time,
                                        want.completion_time);
                    if (rsp.turnaround !== want.turnaround)
                        report_mismatch("turnaround", rsp.turnaround, want.turnaround);
                    if (rsp.waiting !== want.waiting)
                        report_mismatch("waiting", rsp.waiting, want.waiting);
                    if (rsp.all_done !== want.all_done)
                        report_mismatch("all_done", rsp.all_done, want.all_done);
                    if (want.finished)
                        completions++;
                    if (want.idle)
                        idle_ticks++;
                end
            end
            // Count down the long hold; start it once enough results came
            next_hold = hold_left;
            if (next_hold != 0)
                next_hold--;
            else if (!long_hold_done && ticks_checked >= HOLD_AFTER_TICKS)
            begin
                next_hold = HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            hold_left <= next_hold;
            case (pace)
                PACE_RX_SLOW: stall_pct = 82;
                PACE_TX_SLOW: stall_pct = 37;
                default:      stall_pct = 0;
            endcase
            rsp_stall <= (next_hold != 0) || ($urandom_range(99) < stall_pct);
        end
    end

    // Stimulus
    initial
    begin
        int k;
        int j;
        int remaining;
        logic [15:0] last_arr;
        logic [7:0] last_prio;
        logic [15:0] arr;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty table: idle tick that already counts as all done
        offer_ticks(1);
        // Lowest priority first, a zero burst, then a tie at the same arrival
        offer_load(16'd0, 16'd3, 8'd255);
        offer_load(16'd0, 16'd0, 8'd0);
        offer_load(16'd2, 16'd2, 8'd16);
        offer_load(16'd2, 16'd1, 8'd16);
        offer_ticks(7);
        // Job that only arrives at the clock limit: idle tick with work pending
        offer_load(16'hFFFF, 16'd2, 8'd0);
        offer_ticks(1);
        // Longest job, runs in the background behind everything else
        offer_load(16'd3, 16'hFFFF, 8'd255);
        offer_ticks(1);
        wait_drained();

        // Random ticks with a few fresh jobs, the last two tied
        for (k = 0; k < 1300; k++)
        begin
            if (k == 650)
                pace = PACE_TX_SLOW;
            if (k == 20 || k == 280 || k == 540)
            begin
                offer_near_load(last_arr, last_prio);
            end
            else if (k == 541)
                offer_load(last_arr, 16'($urandom_range(300, 1)), last_prio);
            else
                offer_ticks(1);
        end
        wait_drained();

        // No idling on either side from here on
        pace = PACE_FULL;

        // Jobs arriving soon or far in the future; overfill the table
        for (k = 0; k < 500; k++)
        begin
            if (k % 60 == 5)
            begin
                if ($urandom_range(1) == 0)
                    arr = 16'(gen_clock + $urandom_range(200));
                else
                    arr = 16'($urandom);
                offer_load(arr, ($urandom_range(9) == 0) ? 16'd0 :
                           16'($urandom_range(250, 1)), 8'($urandom));
            end
            else
                offer_ticks(1);
        end
        wait_drained();

        // Run part of what is left, then tick a few more times
        remaining = 0;
        for (j = 0; j < sched_count; j++)
            remaining += sched_left[j];
        offer_ticks(((remaining > 80) ? 80 : remaining) + 3);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d loads (%0d dropped on a full table) and %0d ticks",
                 loads_taken, loads_dropped, ticks_checked);
        $display("%0d job completions, %0d idle ticks, scheduler clock at %0d",
                 completions, idle_ticks, sched_clock);
        if (mismatches == 0 && tick_results_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog
    initial
    begin
        #12000000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/pps_pkg.sv
sv/pps_ram.sv
sv/pps_datapath.sv
sv/pps_ctrl.sv
sv/preemptive_priority_scheduler.sv
sv/pps_checker.sv
tb/sv/tb_preemptive_priority_scheduler.sv
